>>> rtl/teadec_pkg.sv
// Package for the TEA block decryptor with a counting key.
// Holds payload structs, the queue entry type and the cipher constants.
// No dependencies; every other rtl file imports it.
`default_nettype none

package teadec_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned KeyWords  = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned Rounds    = 8;
  localparam int unsigned RoundW    = $clog2(Rounds);
  localparam int unsigned QueueDepth = 2;

  localparam logic [WordW-1:0]  SumStart  = 32'hF1BB_CDC8;
  localparam logic [WordW-1:0]  Delta     = 32'h9E37_79B9;
  localparam logic [RoundW-1:0] LastRound = RoundW'(Rounds - 1);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKeyWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyWord3 = 3'd3;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic             restart;
    logic [WordW-1:0] cipher_low;
    logic [WordW-1:0] cipher_high;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] plain_low;
    logic [WordW-1:0] plain_high;
  } out_item_t;

  // One block with the key it decrypts under
  typedef struct packed {
    key_t             key;
    logic [WordW-1:0] lo;
    logic [WordW-1:0] hi;
  } job_t;

  // Queue status handed from the queue to front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

`default_nettype wire

>>> rtl/teadec_front.sv
// Front end: holds the key registers and the running key, accepts requests
// and tags each block with its key. Depends on teadec_pkg.
`default_nettype none

module teadec_front import teadec_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WordW-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_item,
  input  wire q_status_t          q_status,
  output logic                    push,
  output job_t                    push_job
);

  key_t key_word_r;
  key_t running_key_r;
  key_t running_key_nxt;
  key_t key_use;

  // Write a key register; ignore indexes past the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word_r <= '0;
    end else if (cfg_we && cfg_index <= RegKeyWord3) begin
      key_word_r[cfg_index[$clog2(KeyWords)-1:0]] <= cfg_data;
    end
  end

  // Accept whenever the queue has room
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Pick the key for this block and count it up by one
  always_comb begin
    key_use         = in_item.restart ? key_word_r : running_key_r;
    running_key_nxt = running_key_r;
    if (push) begin
      running_key_nxt = key_t'(key_use + 1'b1);
    end
  end

  always_comb begin
    push_job.key = key_use;
    push_job.lo  = in_item.cipher_low;
    push_job.hi  = in_item.cipher_high;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_key_r <= '0;
    end else begin
      running_key_r <= running_key_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/teadec_queue.sv
// Short queue of tagged blocks between the front end and the round engine.
// Depends on teadec_pkg.
`default_nettype none

module teadec_queue import teadec_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       pop_job,
  output q_status_t  status
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign status.full  = (count_r == Full);
  assign status.valid = (count_r != '0);
  assign pop_job      = mem[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> rtl/teadec_back.sv
// Back end: iterative round engine, one TEA decryption cycle per clock
// when not stalled, and the output register. Depends on teadec_pkg.
`default_nettype none

module teadec_back import teadec_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_status,
  input  wire job_t      pop_job,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  function automatic logic [WordW-1:0] mix(
    input logic [WordW-1:0] w,
    input logic [WordW-1:0] sum,
    input logic [WordW-1:0] ka,
    input logic [WordW-1:0] kb
  );
    mix = ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
  endfunction

  logic             busy_r;
  logic [RoundW-1:0] round_r;
  logic [WordW-1:0] lo_r, hi_r, sum_r;
  key_t             key_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic [WordW-1:0] hi_nxt, lo_nxt;
  logic             done, out_free, finish, load;

  // One decryption cycle: high word first, then low word
  always_comb begin
    hi_nxt = hi_r - mix(lo_r, sum_r, key_r[2], key_r[3]);
    lo_nxt = lo_r - mix(hi_nxt, sum_r, key_r[0], key_r[1]);
  end

  assign done     = busy_r && (round_r == LastRound);
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = done && out_free;
  assign load     = q_status.valid && (!busy_r || finish);
  assign pop      = load;

  // Control: start, advance, retire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= '0;
    end else if (load) begin
      busy_r  <= 1'b1;
      round_r <= '0;
    end else if (finish) begin
      busy_r  <= 1'b0;
    end else if (busy_r && !done) begin
      round_r <= round_r + 1'b1;
    end
  end

  // Datapath: load a new block or step the rounds; hold on the last round
  always_ff @(posedge clk) begin
    if (load) begin
      lo_r  <= pop_job.lo;
      hi_r  <= pop_job.hi;
      key_r <= pop_job.key;
      sum_r <= SumStart;
    end else if (busy_r && !done) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      sum_r <= sum_r - Delta;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_item_r.plain_low  <= lo_nxt;
      out_item_r.plain_high <= hi_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> rtl/tea_block_decrypt_counter_key.sv
// Top level of the TEA block decryptor with a counting 128-bit key.
// Instantiates teadec_front, teadec_queue and teadec_back; uses teadec_pkg.
//
//   channel  ports                           direction  moves
//   cfg      cfg_we, cfg_index, cfg_data     in         key word write
//   in       in_valid, in_stall, in_item     in         ciphertext block request
//   out      out_valid, out_stall, out_item  out        plaintext block
//
// The shared round engine works on one block at a time, one decryption cycle
// per clock, and holds on its last cycle while out stalls. It loads the next
// block from the queue in the same cycle as it retires the current one.
// Until full, the queue takes requests while the engine works or out stalls.
// rst_n is synchronous; it clears the key words, running key and all valids.
`default_nettype none

module tea_block_decrypt_counter_key import teadec_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WordW-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_item
);

  q_status_t q_status;
  logic      push, pop;
  job_t      push_job, pop_job;

  teadec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  teadec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  teadec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
